// ===== hdl/pcrc_pkg.sv =====
// Package for the packet CRC-16 checker: constants, item and register types,
// and the byte-wide CRC update. No dependencies.
package pcrc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_SEED_RST  = 16'h1D0F;
  localparam logic [7:0]  FIELD_POS_RST = 8'd8;
  localparam logic [7:0]  POS_MAX       = 8'hFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POS = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  // Input register contents as seen by the core.
  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } stage_t;

  typedef struct packed {
    logic [15:0] crc_seed;
    logic [7:0]  crc_field_pos;
  } cfg_regs_t;

  // One byte through the CRC-16, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int b = 7; b >= 0; b--) begin
      fb = c[15] ^ data[b];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/pcrc_if.sv =====
// Channel interfaces for the packet CRC-16 checker: byte input, result output
// and configuration write. Depends on pcrc_pkg.
interface pcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcrc_result_if;
  logic        valid;
  logic        ready;
  logic        crc_match;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic [7:0]  byte_count;
  modport source (output valid, output crc_match, output computed_crc,
                  output received_crc, output byte_count, input ready);
  modport sink   (input valid, input crc_match, input computed_crc,
                  input received_crc, input byte_count, output ready);
endinterface

interface pcrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcrc_pkg::CFG_IDX_W-1:0]  index;
  logic [pcrc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/packet_crc16_checker.sv =====
// Top level of the packet CRC-16 checker: configuration registers, input
// register and core. Depends on pcrc_pkg, pcrc_if, pcrc_in_stage, pcrc_core.
//
//  port     dir   payload                                        word
//  pkt_in   in    data_byte[7:0], last_byte                      one packet byte
//  result   out   crc_match, computed_crc, received_crc, count   one per packet
//  cfg      in    index[1:0], data[15:0]                         one register write
//
// One byte is taken per cycle; its CRC update and field capture run in the
// cycle after it is registered, and the result register loads on the final byte.
// The final byte is held in the input register, and its result then loads the result register that drives result.valid.
// Reset restores seed 0x1D0F and field position 8 and clears the packet state.
// Only a final byte can stall, when the result register is still full; the
// input register then holds it and pkt_in.ready drops. cfg is always ready.
module packet_crc16_checker (
  input  logic           clk,
  input  logic           rst,
  pcrc_byte_if.sink      pkt_in,
  pcrc_result_if.source  result,
  pcrc_cfg_if.sink       cfg
);

  pcrc_pkg::cfg_regs_t cfg_regs;
  pcrc_pkg::stage_t    stage;
  logic                advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.crc_seed      <= pcrc_pkg::CRC_SEED_RST;
      cfg_regs.crc_field_pos <= pcrc_pkg::FIELD_POS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pcrc_pkg::CFG_SEED:      cfg_regs.crc_seed      <= cfg.data;
        pcrc_pkg::CFG_FIELD_POS: cfg_regs.crc_field_pos <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  pcrc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in),
    .advance (advance),
    .stage   (stage)
  );

  pcrc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .cfg_regs (cfg_regs),
    .advance  (advance),
    .result   (result)
  );

endmodule

// ===== hdl/pcrc_in_stage.sv =====
// Input register of the packet CRC-16 checker: holds one byte until the core
// takes it. Depends on pcrc_pkg and pcrc_if.
module pcrc_in_stage (
  input  logic              clk,
  input  logic              rst,
  pcrc_byte_if.sink         pkt_in,
  input  logic              advance,
  output pcrc_pkg::stage_t  stage
);

  logic                  valid;
  pcrc_pkg::byte_item_t  item;

  assign pkt_in.ready = !valid || advance;
  assign stage.valid  = valid;
  assign stage.item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pkt_in.ready) begin
      valid <= pkt_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_in.valid && pkt_in.ready) begin
      item.data_byte <= pkt_in.data_byte;
      item.last_byte <= pkt_in.last_byte;
    end
  end

endmodule

// ===== hdl/pcrc_core.sv =====
// Packet state and result register of the packet CRC-16 checker: CRC update,
// field capture, byte counting. Depends on pcrc_pkg and pcrc_if.
module pcrc_core (
  input  logic                clk,
  input  logic                rst,
  input  pcrc_pkg::stage_t    stage,
  input  pcrc_pkg::cfg_regs_t cfg_regs,
  output logic                advance,
  pcrc_result_if.source       result
);

  logic [15:0] crc_register;
  logic [7:0]  byte_position;
  logic [15:0] captured_crc;
  logic        past_end;

  logic        out_valid;
  logic        out_match;
  logic [15:0] out_computed;
  logic [15:0] out_received;
  logic [7:0]  out_count;

  logic        exact;
  logic        hi_hit;
  logic        lo_hit;
  logic [15:0] crc_base;
  logic [15:0] crc_register_next;
  logic [15:0] captured_crc_next;
  logic [7:0]  count_next;
  logic        is_last;

  assign is_last = stage.item.last_byte;
  // Non-final bytes never wait on the output side.
  assign advance = stage.valid && (!is_last || !out_valid || result.ready);

  always_comb begin
    exact    = !past_end;
    hi_hit   = exact && (byte_position == cfg_regs.crc_field_pos);
    lo_hit   = exact && ({1'b0, byte_position} == ({1'b0, cfg_regs.crc_field_pos} + 9'd1));
    crc_base = (exact && byte_position == 8'd0) ? cfg_regs.crc_seed : crc_register;

    crc_register_next = crc_base;
    captured_crc_next = captured_crc;
    priority if (hi_hit) begin
      captured_crc_next = {stage.item.data_byte, captured_crc[7:0]};
    end else if (lo_hit) begin
      captured_crc_next = {captured_crc[15:8], stage.item.data_byte};
    end else begin
      crc_register_next = pcrc_pkg::crc_feed(crc_base, stage.item.data_byte);
    end

    count_next = (byte_position == pcrc_pkg::POS_MAX) ? pcrc_pkg::POS_MAX
                                                      : byte_position + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register  <= pcrc_pkg::CRC_SEED_RST;
      byte_position <= 8'd0;
      captured_crc  <= 16'd0;
      past_end      <= 1'b0;
    end else if (advance) begin
      if (is_last) begin
        // restart for the next packet; the seed is loaded on its first byte
        crc_register  <= cfg_regs.crc_seed;
        byte_position <= 8'd0;
        captured_crc  <= 16'd0;
        past_end      <= 1'b0;
      end else begin
        crc_register  <= crc_register_next;
        captured_crc  <= captured_crc_next;
        byte_position <= count_next;
        if (byte_position == pcrc_pkg::POS_MAX) begin
          past_end <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_last) begin
      out_match    <= (crc_register_next == captured_crc_next);
      out_computed <= crc_register_next;
      out_received <= captured_crc_next;
      out_count    <= count_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.crc_match    = out_match;
  assign result.computed_crc = out_computed;
  assign result.received_crc = out_received;
  assign result.byte_count   = out_count;

  // A new result comes only from a final byte taken in the previous cycle.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && is_last))
    else $error("result raised without a final byte");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last) |=> (byte_position == 8'd0 && !past_end && captured_crc == 16'd0))
    else $error("packet state not restarted after final byte");

  a_past_end_pos: assert property (@(posedge clk) disable iff (rst)
    past_end |-> (byte_position == pcrc_pkg::POS_MAX))
    else $error("past_end set below saturated position");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count != 8'd0))
    else $error("result with zero byte count");

endmodule
